FILE: rtl/core/isa_pkg.sv
// shared constants, widths and helper functions for the 16-bit isa step core
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package isa_pkg;

  // word memory depth, a power of two from 512 to 65536
  localparam int MEM_WORDS = 65536;
  localparam int MEM_AW    = $clog2(MEM_WORDS);

  localparam logic [15:0] PC_RESET  = 16'h0200;
  localparam logic [7:0]  HALT_VECT = 8'h25;

  localparam logic [1:0] CMD_WRITE = 2'd0;
  localparam logic [1:0] CMD_EXEC  = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  localparam logic [3:0] OP_BR   = 4'h0;
  localparam logic [3:0] OP_ADD  = 4'h1;
  localparam logic [3:0] OP_LD   = 4'h2;
  localparam logic [3:0] OP_ST   = 4'h3;
  localparam logic [3:0] OP_JSR  = 4'h4;
  localparam logic [3:0] OP_AND  = 4'h5;
  localparam logic [3:0] OP_LDR  = 4'h6;
  localparam logic [3:0] OP_STR  = 4'h7;
  localparam logic [3:0] OP_RTI  = 4'h8;
  localparam logic [3:0] OP_NOT  = 4'h9;
  localparam logic [3:0] OP_LDI  = 4'hA;
  localparam logic [3:0] OP_STI  = 4'hB;
  localparam logic [3:0] OP_JMP  = 4'hC;
  localparam logic [3:0] OP_LEA  = 4'hE;
  localparam logic [3:0] OP_TRAP = 4'hF;

  localparam logic [2:0] REG_SP   = 3'd6;
  localparam logic [2:0] REG_LINK = 3'd7;

  typedef logic [15:0] word_t;

  function automatic logic [2:0] flags_of(input word_t v);
    if (v[15]) begin
      flags_of = 3'b100;
    end else if (v == 16'h0000) begin
      flags_of = 3'b010;
    end else begin
      flags_of = 3'b001;
    end
  endfunction

  function automatic word_t wrap16(input word_t a);
    wrap16 = a & word_t'(MEM_WORDS - 1);
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/isa_ram.sv
// generic single-port synchronous ram with registered read data
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module isa_ram #(
  parameter int AW = 16,
  parameter int DW = 16
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] addr,
  input  wire logic [DW-1:0] wdata,
  output logic      [DW-1:0] rdata
);

  logic [DW-1:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end else begin
      rdata <= mem[addr];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/isa_regfile.sv
// eight-entry general register file, two registered read ports, one write port
// depends on isa_pkg
`timescale 1ns / 1ps
`default_nettype none

module isa_regfile
  import isa_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       rd_en,
  input  wire logic [2:0] rd_addr_a,
  input  wire logic [2:0] rd_addr_b,
  output word_t           rd_data_a,
  output word_t           rd_data_b,
  input  wire logic       wr_en,
  input  wire logic [2:0] wr_addr,
  input  word_t           wr_data
);

  word_t      regs [8];
  logic [7:0] valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (wr_en) begin
      valid_r[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      regs[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_a <= valid_r[rd_addr_a] ? regs[rd_addr_a] : '0;
      rd_data_b <= valid_r[rd_addr_b] ? regs[rd_addr_b] : '0;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/sixteen_bit_isa_step_core.sv
// top level of the 16-bit isa step core: sequencer around word memory and registers
// depends on isa_pkg, isa_ram, isa_regfile
//
//  channel | dir | tdata (low bit up)                          | word
//  in_     | in  | command, address, write_data                | one command
//  out_    | out | read_data .. illegal_opcode (see port list) | one result
//
// memory writes and unknown commands finish from idle, reads pass through a read state, and an instruction
// runs fetch, register read and up to two data accesses through the single memory port.
// after reset a clearing pass zeroes every memory word; no word taken meanwhile.
// a result waits in the output register; the next word is taken as it drains.
`timescale 1ns / 1ps
`default_nettype none

module sixteen_bit_isa_step_core
  import isa_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // command[1:0], address[17:2], write_data[33:18], zero pad
  input  wire logic [39:0]  in_tdata,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // read_data[15:0], program_counter[31:16], instruction[47:32], cond_flags[50:48],
  // halted[51], reg_written[52], reg_index[55:53], reg_value[71:56], mem_written[72],
  // store_address[88:73], store_value[104:89], illegal_opcode[105], zero pad
  output logic [111:0]      out_tdata
);

  localparam logic [2:0] S_CLR   = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_RD    = 3'd2;
  localparam logic [2:0] S_FETCH = 3'd3;
  localparam logic [2:0] S_REG   = 3'd4;
  localparam logic [2:0] S_M1    = 3'd5;
  localparam logic [2:0] S_M2    = 3'd6;

  logic [2:0]    state_r, state_nxt;
  logic [MEM_AW:0] clr_cnt_r;
  word_t         pc_r, pc_nxt;
  logic [2:0]    flags_r;
  logic          halt_r;
  word_t         ir_r;
  logic          out_valid_r;
  logic [105:0]  out_r;

  logic [1:0]    in_cmd;
  word_t         in_addr, in_wdata;
  logic          in_fire;

  logic              mem_we;
  logic [MEM_AW-1:0] mem_addr;
  word_t             mem_wd, mem_q;

  logic       rf_rd_en;
  logic [2:0] rf_addr_a, rf_addr_b;
  word_t      ra, rb;

  logic [3:0] op;
  word_t      off9, src2, ldr_ea, jsr_t;

  logic       fin, f_rwr, f_mwr, f_ill, f_setcc, f_halt;
  logic [2:0] f_ridx;
  word_t      f_rval, f_saddr, f_sval, f_rdata, f_instr;

  assign in_cmd   = in_tdata[1:0];
  assign in_addr  = in_tdata[17:2];
  assign in_wdata = in_tdata[33:18];
  assign in_tready = (state_r == S_IDLE) && (!out_valid_r || out_tready);
  assign in_fire  = in_tvalid && in_tready;

  assign op     = ir_r[15:12];
  assign off9   = pc_r + {{7{ir_r[8]}}, ir_r[8:0]};
  assign src2   = ir_r[5] ? {{11{ir_r[4]}}, ir_r[4:0]} : rb;
  assign ldr_ea = ra + {{10{ir_r[5]}}, ir_r[5:0]};
  assign jsr_t  = ir_r[11] ? pc_r + {{5{ir_r[10]}}, ir_r[10:0]} : ra;

  isa_ram #(.AW(MEM_AW), .DW(16)) u_ram (
    .clk  (clk),
    .we   (mem_we),
    .addr (mem_addr),
    .wdata(mem_wd),
    .rdata(mem_q)
  );

  isa_regfile u_rf (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_en    (rf_rd_en),
    .rd_addr_a(rf_addr_a),
    .rd_addr_b(rf_addr_b),
    .rd_data_a(ra),
    .rd_data_b(rb),
    .wr_en    (fin && f_rwr),
    .wr_addr  (f_ridx),
    .wr_data  (f_rval)
  );

  // register read addresses come straight from the fetched word
  always_comb begin
    rf_rd_en  = (state_r == S_FETCH);
    rf_addr_a = (mem_q[15:12] == OP_RTI) ? REG_SP : mem_q[8:6];
    rf_addr_b = (mem_q[15:12] inside {OP_ST, OP_STI, OP_STR}) ? mem_q[11:9] : mem_q[2:0];
  end

  always_comb begin
    state_nxt = state_r;
    pc_nxt    = pc_r;
    mem_we    = 1'b0;
    mem_addr  = '0;
    mem_wd    = '0;
    fin       = 1'b0;
    f_rwr     = 1'b0;
    f_ridx    = '0;
    f_rval    = '0;
    f_setcc   = 1'b0;
    f_mwr     = 1'b0;
    f_saddr   = '0;
    f_sval    = '0;
    f_ill     = 1'b0;
    f_halt    = halt_r;
    f_rdata   = '0;
    f_instr   = ir_r;
    case (state_r)
      S_CLR: begin
        mem_we   = 1'b1;
        mem_addr = clr_cnt_r[MEM_AW-1:0];
        if (clr_cnt_r[MEM_AW-1:0] == {MEM_AW{1'b1}}) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        f_instr = '0;
        if (in_fire) begin
          if (in_cmd == CMD_WRITE) begin
            mem_we   = 1'b1;
            mem_addr = in_addr[MEM_AW-1:0];
            mem_wd   = in_wdata;
            fin      = 1'b1;
          end else if (in_cmd == CMD_READ) begin
            mem_addr  = in_addr[MEM_AW-1:0];
            state_nxt = S_RD;
          end else if (in_cmd == CMD_EXEC && !halt_r) begin
            mem_addr  = pc_r[MEM_AW-1:0];
            state_nxt = S_FETCH;
          end else begin
            fin = 1'b1;
          end
        end
      end
      S_RD: begin
        f_instr   = '0;
        f_rdata   = mem_q;
        fin       = 1'b1;
        state_nxt = S_IDLE;
      end
      S_FETCH: begin
        pc_nxt    = pc_r + 16'd1;
        state_nxt = S_REG;
      end
      S_REG: begin
        state_nxt = S_IDLE;
        case (op)
          OP_ADD, OP_AND, OP_NOT, OP_LEA: begin
            fin     = 1'b1;
            f_rwr   = 1'b1;
            f_ridx  = ir_r[11:9];
            f_setcc = 1'b1;
            if (op == OP_ADD) begin
              f_rval = ra + src2;
            end else if (op == OP_AND) begin
              f_rval = ra & src2;
            end else if (op == OP_NOT) begin
              f_rval = ~ra;
            end else begin
              f_rval = off9;
            end
          end
          OP_BR: begin
            fin = 1'b1;
            if ((ir_r[11:9] & flags_r) != 3'b000) begin
              pc_nxt = off9;
            end
          end
          OP_JMP: begin
            fin    = 1'b1;
            pc_nxt = ra;
          end
          OP_JSR: begin
            fin    = 1'b1;
            f_rwr  = 1'b1;
            f_ridx = REG_LINK;
            f_rval = pc_r;
            pc_nxt = jsr_t;
          end
          OP_ST, OP_STR: begin
            fin      = 1'b1;
            f_mwr    = 1'b1;
            f_saddr  = wrap16((op == OP_ST) ? off9 : ldr_ea);
            f_sval   = rb;
            mem_we   = 1'b1;
            mem_addr = f_saddr[MEM_AW-1:0];
            mem_wd   = rb;
          end
          OP_LD, OP_LDI, OP_STI: begin
            mem_addr  = off9[MEM_AW-1:0];
            state_nxt = S_M1;
          end
          OP_LDR: begin
            mem_addr  = ldr_ea[MEM_AW-1:0];
            state_nxt = S_M1;
          end
          OP_RTI: begin
            mem_addr  = ra[MEM_AW-1:0];
            state_nxt = S_M1;
          end
          OP_TRAP: begin
            if (ir_r[7:0] == HALT_VECT) begin
              fin    = 1'b1;
              f_rwr  = 1'b1;
              f_ridx = REG_LINK;
              f_rval = pc_r;
              f_halt = 1'b1;
            end else begin
              mem_addr  = {{(MEM_AW - 8){1'b0}}, ir_r[7:0]};
              state_nxt = S_M1;
            end
          end
          default: begin
            fin   = 1'b1;
            f_ill = 1'b1;
          end
        endcase
      end
      S_M1: begin
        state_nxt = S_IDLE;
        case (op)
          OP_LD, OP_LDR: begin
            fin     = 1'b1;
            f_rwr   = 1'b1;
            f_ridx  = ir_r[11:9];
            f_rval  = mem_q;
            f_setcc = 1'b1;
          end
          OP_LDI: begin
            mem_addr  = mem_q[MEM_AW-1:0];
            state_nxt = S_M2;
          end
          OP_STI: begin
            fin      = 1'b1;
            f_mwr    = 1'b1;
            f_saddr  = wrap16(mem_q);
            f_sval   = rb;
            mem_we   = 1'b1;
            mem_addr = mem_q[MEM_AW-1:0];
            mem_wd   = rb;
          end
          OP_RTI: begin
            fin    = 1'b1;
            f_rwr  = 1'b1;
            f_ridx = REG_SP;
            f_rval = ra + 16'd2;
            pc_nxt = mem_q;
          end
          default: begin
            // trap through vector table
            fin    = 1'b1;
            f_rwr  = 1'b1;
            f_ridx = REG_LINK;
            f_rval = pc_r;
            pc_nxt = mem_q;
          end
        endcase
      end
      S_M2: begin
        fin       = 1'b1;
        f_rwr     = 1'b1;
        f_ridx    = ir_r[11:9];
        f_rval    = mem_q;
        f_setcc   = 1'b1;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_cnt_r   <= '0;
      pc_r        <= PC_RESET;
      flags_r     <= '0;
      halt_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pc_r    <= pc_nxt;
      halt_r  <= f_halt;
      if (state_r == S_CLR) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
      end
      if (fin && f_setcc) begin
        flags_r <= flags_of(f_rval);
      end
      if (fin) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_FETCH) begin
      ir_r <= mem_q;
    end
    if (fin) begin
      out_r <= {f_ill, f_sval, f_saddr, f_mwr, f_rval, f_ridx, f_rwr, f_halt,
                (f_setcc ? flags_of(f_rval) : flags_r), f_instr, pc_nxt, f_rdata};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'b000000, out_r};

endmodule

`default_nettype wire

FILE: bench/isa_step_checker.sv
// result checker for the 16-bit isa step core: watches both streams, predicts each result
// and compares it field by field with what the core sends; depends on isa_pkg
`timescale 1ns / 1ps

module isa_step_checker
  import isa_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  input  logic         in_tready,
  // command[1:0], address[17:2], write_data[33:18], zero pad
  input  logic [39:0]  in_tdata,
  input  logic         out_tvalid,
  input  logic         out_tready,
  // read_data[15:0] .. illegal_opcode[105], zero pad
  input  logic [111:0] out_tdata,
  output int           fail_count,
  output int           pending
);

  typedef struct packed {
    word_t      read_data;
    word_t      pc;
    word_t      instr;
    logic [2:0] flags;
    logic       halted;
    logic       reg_wr;
    logic [2:0] reg_idx;
    word_t      reg_val;
    logic       mem_wr;
    word_t      st_addr;
    word_t      st_val;
    logic       illegal;
  } step_result_t;

  localparam word_t ADDR_MASK = word_t'(MEM_WORDS - 1);

  word_t        mem_model [0:MEM_WORDS-1];
  word_t        gpr [0:7];
  word_t        pc_q;
  logic [2:0]   nzp_q;
  logic         halt_q;
  step_result_t result_q [$];

  assign pending = result_q.size();

  function automatic word_t sx(input word_t v, input int bits);
    word_t m;
    m = word_t'((32'd1 << bits) - 1);
    v = v & m;
    if (v[bits-1]) v = v | ~m;
    return v;
  endfunction

  function automatic logic [2:0] nzp_of(input word_t v);
    if (v[15]) return 3'b100;
    if (v == 16'h0000) return 3'b010;
    return 3'b001;
  endfunction

  function automatic word_t rd(input word_t a);
    return mem_model[a & ADDR_MASK];
  endfunction

  task automatic run_command(input logic [1:0] cmd, input word_t addr, input word_t wd,
                             output step_result_t r);
    logic [3:0] op;
    logic [2:0] dr, sr1;
    word_t      pcn, off9, src2, t, ea;
    logic       setcc;
    r = '0;
    setcc = 1'b0;
    if (cmd == CMD_WRITE) begin
      mem_model[addr & ADDR_MASK] = wd;
    end else if (cmd == CMD_READ) begin
      r.read_data = rd(addr);
    end else if (cmd == CMD_EXEC && !halt_q) begin
      r.instr = rd(pc_q);
      pc_q = pc_q + 16'd1;
      pcn = pc_q;
      op = r.instr[15:12];
      dr = r.instr[11:9];
      sr1 = r.instr[8:6];
      off9 = pcn + sx(r.instr, 9);
      src2 = r.instr[5] ? sx(r.instr, 5) : gpr[r.instr[2:0]];
      case (op)
        OP_ADD: begin r.reg_val = gpr[sr1] + src2; r.reg_wr = 1; setcc = 1; end
        OP_AND: begin r.reg_val = gpr[sr1] & src2; r.reg_wr = 1; setcc = 1; end
        OP_NOT: begin r.reg_val = ~gpr[sr1]; r.reg_wr = 1; setcc = 1; end
        OP_BR: begin
          if ((dr & nzp_q) != 0) pc_q = off9;
        end
        OP_JMP: pc_q = gpr[sr1];
        OP_JSR: begin
          t = r.instr[11] ? pcn + sx(r.instr, 11) : gpr[sr1];
          dr = REG_LINK; r.reg_val = pcn; r.reg_wr = 1;
          pc_q = t;
        end
        OP_LD: begin r.reg_val = rd(off9); r.reg_wr = 1; setcc = 1; end
        OP_LDI: begin r.reg_val = rd(rd(off9)); r.reg_wr = 1; setcc = 1; end
        OP_LDR: begin
          r.reg_val = rd(gpr[sr1] + sx(r.instr, 6)); r.reg_wr = 1; setcc = 1;
        end
        OP_LEA: begin r.reg_val = off9; r.reg_wr = 1; setcc = 1; end
        OP_ST, OP_STI, OP_STR: begin
          if (op == OP_ST) ea = off9;
          else if (op == OP_STI) ea = rd(off9);
          else ea = gpr[sr1] + sx(r.instr, 6);
          r.st_addr = ea & ADDR_MASK;
          r.st_val = gpr[dr];
          mem_model[r.st_addr] = r.st_val;
          r.mem_wr = 1;
        end
        OP_RTI: begin
          pc_q = rd(gpr[REG_SP]);
          dr = REG_SP; r.reg_val = gpr[REG_SP] + 16'd2; r.reg_wr = 1;
        end
        OP_TRAP: begin
          dr = REG_LINK; r.reg_val = pcn; r.reg_wr = 1;
          t = {8'h00, r.instr[7:0]};
          if (r.instr[7:0] == HALT_VECT) halt_q = 1'b1;
          else pc_q = rd(t);
        end
        default: r.illegal = 1'b1;
      endcase
      if (r.reg_wr) begin
        gpr[dr] = r.reg_val;
        r.reg_idx = dr;
      end
      if (setcc) nzp_q = nzp_of(r.reg_val);
    end
    r.pc = pc_q;
    r.flags = nzp_q;
    r.halted = halt_q;
  endtask

  task automatic check_field(input string name, input word_t exp_v, input word_t act_v);
    if (exp_v !== act_v) begin
      if (fail_count < 10)
        $display("mismatch %s: expected %h, got %h at %0t", name, exp_v, act_v, $realtime);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    step_result_t r, a;
    if (!rst_n) begin
      for (int i = 0; i < MEM_WORDS; i++) mem_model[i] = '0;
      for (int i = 0; i < 8; i++) gpr[i] = '0;
      pc_q = PC_RESET;
      nzp_q = '0;
      halt_q = 1'b0;
      result_q.delete();
      fail_count = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        a = '{read_data: out_tdata[15:0], pc: out_tdata[31:16], instr: out_tdata[47:32],
              flags: out_tdata[50:48], halted: out_tdata[51], reg_wr: out_tdata[52],
              reg_idx: out_tdata[55:53], reg_val: out_tdata[71:56], mem_wr: out_tdata[72],
              st_addr: out_tdata[88:73], st_val: out_tdata[104:89],
              illegal: out_tdata[105]};
        if (result_q.size() == 0) begin
          if (fail_count < 10) $display("unexpected word on output at %0t", $realtime);
          fail_count++;
        end else begin
          r = result_q.pop_front();
          check_field("read_data", r.read_data, a.read_data);
          check_field("program_counter", r.pc, a.pc);
          check_field("instruction", r.instr, a.instr);
          check_field("cond_flags", word_t'(r.flags), word_t'(a.flags));
          check_field("halted", word_t'(r.halted), word_t'(a.halted));
          check_field("reg_written", word_t'(r.reg_wr), word_t'(a.reg_wr));
          check_field("reg_index", word_t'(r.reg_idx), word_t'(a.reg_idx));
          check_field("reg_value", r.reg_val, a.reg_val);
          check_field("mem_written", word_t'(r.mem_wr), word_t'(a.mem_wr));
          check_field("store_address", r.st_addr, a.st_addr);
          check_field("store_value", r.st_val, a.st_val);
          check_field("illegal_opcode", word_t'(r.illegal), word_t'(a.illegal));
        end
      end
      if (in_tvalid && in_tready) begin
        run_command(in_tdata[1:0], in_tdata[17:2], in_tdata[33:18], r);
        result_q.push_back(r);
      end
    end
  end

endmodule

FILE: bench/testbench.sv
// top of the bench for the 16-bit isa step core: clock, reset, command stimulus and verdict
// depends on isa_pkg, sixteen_bit_isa_step_core and isa_step_checker
`timescale 1ns / 1ps

module testbench;
  import isa_pkg::*;

  localparam int IDLE_LIMIT = 300000;
  localparam int RANDOM_ITEMS = 1520;
  localparam logic [1:0] CMD_NONE = 2'd3;

  logic         clk = 1'b0;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [39:0]  in_tdata;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [111:0] out_tdata;
  int           fail_count;
  int           pending;
  int           words_sent;
  int           words_back = 0;
  int           idle_cycles = 0;
  logic         no_gaps;
  word_t        last_pc = PC_RESET;

  always #10 clk = ~clk;

  sixteen_bit_isa_step_core u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  isa_step_checker u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .fail_count(fail_count), .pending(pending)
  );

  always @(posedge clk) begin
    out_tready <= no_gaps ? 1'b1 : ($urandom_range(0, 99) >= 23);
    if (rst_n && out_tvalid && out_tready) begin
      words_back <= words_back + 1;
      last_pc <= out_tdata[31:16];
    end
  end

  // watchdog: cycles with no word moving on either side
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("testbench: FAIL");
      $finish;
    end
  end

  task automatic send(input logic [1:0] cmd, input word_t addr, input word_t wd);
    if (!no_gaps && $urandom_range(0, 99) < 23) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_tdata <= {6'd0, wd, addr, cmd};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    words_sent++;
  endtask

  // drain so that last_pc is the pc the next execute will fetch from
  task automatic catch_up();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (words_back != words_sent);
  endtask

  function automatic word_t rand_instr(input logic [3:0] op);
    word_t w;
    w = {op, 12'($urandom)};
    if (op == OP_TRAP && w[7:0] == HALT_VECT) w[7:0] = 8'h20;
    return w;
  endfunction

  task automatic program_step(input word_t instr);
    catch_up();
    send(CMD_WRITE, last_pc, instr);
    send(CMD_EXEC, 16'h0, 16'h0);
  endtask

  initial begin
    word_t a;
    int    pick;
    rst_n <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata <= '0;
    no_gaps <= 1'b0;
    words_sent = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: flags still clear so branch falls through, extremes of address and data
    send(CMD_EXEC, 16'hFFFF, 16'hFFFF);
    send(CMD_WRITE, 16'hFFFF, 16'hFFFF);
    send(CMD_READ, 16'hFFFF, 16'h0000);
    send(CMD_WRITE, 16'h0000, 16'h8000);
    send(CMD_NONE, 16'hFFFF, 16'hFFFF);
    program_step(16'h1270);  // add r1, r1, #-16
    program_step(16'h166F);  // add r3, r1, #15
    program_step(16'h0E05);  // branch always
    for (int op = 0; op < 16; op++) program_step(rand_instr(4'(op)));
    program_step(16'h41C0);  // jsrr through r7
    program_step(16'h8000);  // return from interrupt

    for (int n = 0; n < RANDOM_ITEMS; ) begin
      no_gaps <= (n >= 600 && n < 800);
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        program_step(rand_instr(4'($urandom_range(0, 15))));
        n += 2;
      end else if (pick < 72) begin
        a = $urandom_range(0, 1) ? word_t'($urandom) : word_t'($urandom_range(0, 16'h3FF));
        send(CMD_WRITE, a, word_t'($urandom));
        n++;
      end else if (pick < 84) begin
        a = $urandom_range(0, 1) ? word_t'($urandom) : word_t'($urandom_range(0, 16'h3FF));
        send(CMD_READ, a, word_t'($urandom));
        n++;
      end else if (pick < 96) begin
        send(CMD_EXEC, word_t'($urandom), word_t'($urandom));
        n++;
      end else begin
        send(CMD_NONE, word_t'($urandom), word_t'($urandom));
        n++;
      end
    end
    no_gaps <= 1'b0;

    // halt trap, then commands after halt
    program_step(16'hF025);
    send(CMD_EXEC, 16'h0, 16'h0);
    send(CMD_WRITE, 16'h0123, 16'hBEEF);
    send(CMD_READ, 16'h0123, 16'h0);

    catch_up();
    repeat (20) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
